// ----- src/arpt_pkg.sv -----
// ----------------------------------------------------------------------------
// Address range profile table package
// Shared constants, entry and row types, state and status codes.
// ----------------------------------------------------------------------------
package arpt_pkg;

	localparam int SET_COUNT = 1024;
	localparam int WAY_COUNT = 4;
	localparam int SET_BITS = $clog2(SET_COUNT);
	localparam int WAY_BITS = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
	localparam int DATA_W = 32;

	localparam logic signed [DATA_W-1:0] ABSENT_MIN = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] ABSENT_MAX = 32'sh8000_0000;

	typedef enum logic {
		OP_OBSERVE = 1'b0,
		OP_QUERY   = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_UPDATED = 3'd0,
		ST_NEW     = 3'd1,
		ST_FULL    = 3'd2,
		ST_QHIT    = 3'd3,
		ST_QMISS   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_LOOKUP
	} fsm_t;

	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] addr;
		logic [DATA_W-1:0] min;
		logic [DATA_W-1:0] max;
	} way_t;

	typedef way_t [WAY_COUNT-1:0] row_t;

endpackage

// ----- src/address_range_profile_table_unit.sv -----
// ----------------------------------------------------------------------------
// Address range profile table unit
// Set-associative table of the signed minimum and maximum value per address.
// ----------------------------------------------------------------------------
// After reset the unit sweeps its table memory once, one set per cycle, over
// all SET_COUNT sets (1024) while tready stays low. Each word then passes two
// steps: it reads its set from the single-port table memory, then compares
// all ways, writes the entry back and loads the output register. A
// finished word waits in that output register, so the next input word is
// taken while the result is still unclaimed; a new lookup completes only once
// the output register is free. The set is chosen by the low address bits.
module address_range_profile_table_unit
	import arpt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // address [31:0], value [63:32]
	input  logic [0:0]  s_axis_tuser,  // op [0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // range_min [31:0], range_max [63:32]
	output logic [2:0]  m_axis_tuser   // status [2:0]
);

	fsm_t state_q, state_d;

	row_t mem [SET_COUNT];
	row_t rd_row_q;
	logic mem_we;
	logic [SET_BITS-1:0] mem_widx;
	row_t mem_wrow;

	logic [SET_BITS-1:0] clr_idx_q;

	logic                     op_s1;
	logic [DATA_W-1:0]        addr_s1;
	logic signed [DATA_W-1:0] value_s1;
	logic [SET_BITS-1:0]      set_s1;

	logic                     out_valid_q;
	status_t                  out_status_q;
	logic signed [DATA_W-1:0] out_min_q, out_max_q;

	logic in_accept;
	logic load;
	logic hit_found, free_found;
	logic [WAY_BITS-1:0] hit_way, free_way;
	way_t hit_entry;
	logic signed [DATA_W-1:0] new_min, new_max;
	status_t                  res_status;
	logic signed [DATA_W-1:0] res_min, res_max;

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign load = (state_q == FSM_LOOKUP) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_widx] <= mem_wrow;
		end
		if (in_accept) begin
			rd_row_q <= mem[s_axis_tdata[SET_BITS-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1    <= s_axis_tuser[0];
			addr_s1  <= s_axis_tdata[31:0];
			value_s1 <= s_axis_tdata[63:32];
			set_s1   <= s_axis_tdata[SET_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FSM_CLEAR;
			clr_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == FSM_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_comb begin
		hit_found  = 1'b0;
		free_found = 1'b0;
		hit_way    = '0;
		free_way   = '0;
		for (int w = WAY_COUNT - 1; w >= 0; w--) begin
			if (rd_row_q[w].valid && rd_row_q[w].addr == addr_s1) begin
				hit_found = 1'b1;
				hit_way   = WAY_BITS'(w);
			end
			if (!rd_row_q[w].valid) begin
				free_found = 1'b1;
				free_way   = WAY_BITS'(w);
			end
		end
		hit_entry = rd_row_q[hit_way];
		new_min = (value_s1 < $signed(hit_entry.min)) ? value_s1 : $signed(hit_entry.min);
		new_max = ($signed(hit_entry.max) < value_s1) ? value_s1 : $signed(hit_entry.max);
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		mem_we        = 1'b0;
		mem_widx      = set_s1;
		mem_wrow      = rd_row_q;
		res_status    = ST_QMISS;
		res_min       = ABSENT_MIN;
		res_max       = ABSENT_MAX;

		if (op_s1 == OP_QUERY) begin
			if (hit_found) begin
				res_status = ST_QHIT;
				res_min    = $signed(hit_entry.min);
				res_max    = $signed(hit_entry.max);
			end
		end else if (hit_found) begin
			res_status = ST_UPDATED;
			res_min    = new_min;
			res_max    = new_max;
			mem_wrow[hit_way].min = new_min;
			mem_wrow[hit_way].max = new_max;
		end else if (free_found) begin
			res_status = ST_NEW;
			res_min    = value_s1;
			res_max    = value_s1;
			mem_wrow[free_way].valid = 1'b1;
			mem_wrow[free_way].addr  = addr_s1;
			mem_wrow[free_way].min   = value_s1;
			mem_wrow[free_way].max   = value_s1;
		end else begin
			res_status = ST_FULL;
		end

		unique case (state_q)
			FSM_CLEAR: begin
				mem_we   = 1'b1;
				mem_widx = clr_idx_q;
				mem_wrow = '0;
				if (clr_idx_q == SET_BITS'(SET_COUNT - 1)) begin
					state_d = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = FSM_LOOKUP;
				end
			end
			FSM_LOOKUP: begin
				if (load) begin
					mem_we  = (op_s1 == OP_OBSERVE) && (hit_found || free_found);
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= res_status;
			out_min_q    <= res_min;
			out_max_q    <= res_max;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_max_q, out_min_q};
	assign m_axis_tuser  = out_status_q;

`ifndef ASSERT_OFF
	a_accept_to_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == FSM_LOOKUP)
		else $error("accepted word did not enter lookup");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_CLEAR |-> !s_axis_tready)
		else $error("input ready during table clear");

	a_query_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_LOOKUP && op_s1 == OP_QUERY) |-> !mem_we)
		else $error("query wrote the table");

	a_new_only_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(load && res_status == ST_NEW) |-> (!hit_found && free_found))
		else $error("allocation despite hit or full set");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address range profile table testbench
// Sends observe and query words with random gaps and checks every result word
// against a local copy of the set-associative min/max table. Most random words
// reuse a small pool of keys in a few sets, so entries are widened, sets fill
// up, and further keys in those sets are dropped.
// ----------------------------------------------------------------------------
module testbench;
	import arpt_pkg::*;

	typedef struct {
		status_t                   status;
		logic signed [DATA_W-1:0]  range_min;
		logic signed [DATA_W-1:0]  range_max;
	} range_result_t;

	localparam int ENTRY_COUNT = SET_COUNT * WAY_COUNT;
	localparam int POOL_SETS = 8;
	localparam int POOL_KEYS = 6;
	localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	bit                       table_valid [ENTRY_COUNT];
	logic [DATA_W-1:0]        table_addr  [ENTRY_COUNT];
	logic signed [DATA_W-1:0] table_min   [ENTRY_COUNT];
	logic signed [DATA_W-1:0] table_max   [ENTRY_COUNT];

	range_result_t     pending_ranges[$];
	range_result_t     oldest_range;
	logic [DATA_W-1:0] key_pool[POOL_SETS * POOL_KEYS];
	bit                no_gaps;
	int                error_count;

	address_range_profile_table_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic range_result_t predict_range(op_t op, logic [DATA_W-1:0] addr,
			logic signed [DATA_W-1:0] val);
		range_result_t res;
		int base;
		int hit_way;
		int free_way;
		int idx;
		base = (addr % SET_COUNT) * WAY_COUNT;
		hit_way = -1;
		free_way = -1;
		for (int w = 0; w < WAY_COUNT; w++) begin
			if (table_valid[base + w]) begin
				if (hit_way < 0 && table_addr[base + w] == addr)
					hit_way = w;
			end else if (free_way < 0) begin
				free_way = w;
			end
		end
		if (op == OP_QUERY) begin
			if (hit_way >= 0) begin
				idx = base + hit_way;
				res = '{ST_QHIT, table_min[idx], table_max[idx]};
			end else begin
				res = '{ST_QMISS, ABSENT_MIN, ABSENT_MAX};
			end
		end else if (hit_way >= 0) begin
			idx = base + hit_way;
			if (val < table_min[idx])
				table_min[idx] = val;
			if (val > table_max[idx])
				table_max[idx] = val;
			res = '{ST_UPDATED, table_min[idx], table_max[idx]};
		end else if (free_way >= 0) begin
			idx = base + free_way;
			table_valid[idx] = 1'b1;
			table_addr[idx] = addr;
			table_min[idx] = val;
			table_max[idx] = val;
			res = '{ST_NEW, val, val};
		end else begin
			res = '{ST_FULL, ABSENT_MIN, ABSENT_MAX};
		end
		return res;
	endfunction

	task automatic send_word(op_t op, logic [DATA_W-1:0] addr, logic signed [DATA_W-1:0] val);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {val, addr};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		pending_ranges.push_back(predict_range(op, addr, val));
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_ranges.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] key_in_set(logic [DATA_W-1:0] upper, int set_index);
		logic [DATA_W-1:0] key;
		key = upper;
		key[SET_BITS-1:0] = set_index[SET_BITS-1:0];
		return key;
	endfunction

	function automatic logic signed [DATA_W-1:0] draw_value();
		case ($urandom_range(0, 15))
			0: return INT_MIN;
			1: return INT_MAX;
			2: return 0;
			3: return -1;
			default: return $urandom();
		endcase
	endfunction

	task automatic refill_key_pool();
		int set_index;
		for (int s = 0; s < POOL_SETS; s++) begin
			set_index = $urandom_range(0, SET_COUNT - 1);
			for (int k = 0; k < POOL_KEYS; k++)
				key_pool[s * POOL_KEYS + k] = key_in_set($urandom(), set_index);
		end
	endtask

	task automatic test_empty_table();
		send_word(OP_QUERY, 32'h0000_0000, 32'hFFFF_FFFF);
		send_word(OP_QUERY, 32'hFFFF_FFFF, 32'h0000_0000);
	endtask

	task automatic test_widen_range();
		send_word(OP_OBSERVE, 32'h0000_0000, INT_MIN);
		send_word(OP_OBSERVE, 32'h0000_0000, INT_MAX);
		send_word(OP_OBSERVE, 32'h0000_0000, 0);
		send_word(OP_QUERY, 32'h0000_0000, $urandom());
		send_word(OP_OBSERVE, 32'h0000_0400, 5);
		send_word(OP_OBSERVE, 32'h0000_0400, -7);
		send_word(OP_OBSERVE, 32'h0000_0400, 3);
		send_word(OP_QUERY, 32'h0000_0400, $urandom());
	endtask

	task automatic test_full_set();
		for (int k = 0; k <= WAY_COUNT; k++)
			send_word(OP_OBSERVE, key_in_set(32'hFFFF_FFFF - k * SET_COUNT, SET_COUNT - 1),
				(k % 2 == 0) ? INT_MAX : INT_MIN);
		send_word(OP_QUERY, key_in_set(32'hFFFF_FFFF - WAY_COUNT * SET_COUNT, SET_COUNT - 1), 0);
		send_word(OP_QUERY, 32'hFFFF_FFFF, 0);
		send_word(OP_OBSERVE, 32'hFFFF_FFFF, -1);
		send_word(OP_QUERY, 32'hFFFF_FFFF, INT_MIN);
	endtask

	task automatic test_random_traffic(int word_total);
		op_t               op;
		logic [DATA_W-1:0] addr;
		int                pick;
		for (int n = 0; n < word_total; n++) begin
			if (n % 125 == 0) begin
				refill_key_pool();
				no_gaps = ($urandom_range(0, 3) == 0);
			end
			if (n == word_total / 2)
				wait_for_results();
			pick = $urandom_range(0, 9);
			addr = key_pool[$urandom_range(0, POOL_SETS * POOL_KEYS - 1)];
			if (pick == 8)
				addr = $urandom();
			else if (pick == 9)
				addr = key_in_set($urandom(), int'(addr[SET_BITS-1:0]));
			op = ($urandom_range(0, 3) == 0) ? OP_QUERY : OP_OBSERVE;
			send_word(op, addr, draw_value());
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 6);
			if (stall != 0) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			@(negedge clk);
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_ranges.size() == 0) begin
				$error("result word with no outstanding request");
				error_count++;
			end else begin
				oldest_range = pending_ranges.pop_front();
				if (m_axis_tuser !== oldest_range.status) begin
					$error("status: expected %0d, got %0d", oldest_range.status, m_axis_tuser);
					error_count++;
				end
				if (m_axis_tdata[31:0] !== oldest_range.range_min) begin
					$error("range_min: expected %0d, got %0d", oldest_range.range_min,
						$signed(m_axis_tdata[31:0]));
					error_count++;
				end
				if (m_axis_tdata[63:32] !== oldest_range.range_max) begin
					$error("range_max: expected %0d, got %0d", oldest_range.range_max,
						$signed(m_axis_tdata[63:32]));
					error_count++;
				end
			end
		end
	end

	initial begin
		error_count = 0;
		no_gaps = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			table_valid[i] = 1'b0;
			table_addr[i] = '0;
			table_min[i] = '0;
			table_max[i] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_widen_range();
		test_full_set();
		wait_for_results();
		test_random_traffic(1030);
		wait_for_results();
		repeat (10) @(posedge clk);

		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
